>>> rtl/core/dependency_count_task_dispatcher_assert.svh
// ----------------------------------------------------------------------------
// Dispatcher assertion macros
// Concurrent assertion shorthands shared by the dispatcher RTL.
// ----------------------------------------------------------------------------
`ifndef DEPENDENCY_COUNT_TASK_DISPATCHER_ASSERT_SVH
`define DEPENDENCY_COUNT_TASK_DISPATCHER_ASSERT_SVH

// cons must hold in the same cycle as ante
`define DCTD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define DCTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// cond must never hold
`define DCTD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> rtl/core/dctd_pkg.sv
// ----------------------------------------------------------------------------
// Dispatcher package
// Field widths, request codes and table word layouts.
// ----------------------------------------------------------------------------
package dctd_pkg;

  localparam int IDX_W     = 5;
  localparam int CNT_W     = 8;
  localparam int RES_DEPTH = 3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } link_t;

  typedef struct packed {
    logic  op;
    link_t s2;
    link_t s1;
  } entry_t;

endpackage

>>> rtl/core/dctd_if.sv
// ----------------------------------------------------------------------------
// Dispatcher channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface dctd_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [dctd_pkg::IDX_W-1:0] task_index;
  logic [dctd_pkg::IDX_W-1:0] pred_count;
  logic                       succ1_valid;
  logic [dctd_pkg::IDX_W-1:0] succ1_index;
  logic                       succ2_valid;
  logic [dctd_pkg::IDX_W-1:0] succ2_index;
  logic                       op_kind;

  modport source (
    output valid, req_type, task_index, pred_count, succ1_valid, succ1_index,
           succ2_valid, succ2_index, op_kind,
    input  ready
  );
  modport sink (
    input  valid, req_type, task_index, pred_count, succ1_valid, succ1_index,
           succ2_valid, succ2_index, op_kind,
    output ready
  );
endinterface

interface dctd_out_if;
  logic                       valid;
  logic                       ready;
  logic [dctd_pkg::IDX_W-1:0] dispatched_index;
  logic                       dispatched_op;
  logic                       none_ready;
  logic                       last;

  modport source (
    output valid, dispatched_index, dispatched_op, none_ready, last,
    input  ready
  );
  modport sink (
    input  valid, dispatched_index, dispatched_op, none_ready, last,
    output ready
  );
endinterface

>>> rtl/core/dctd_ram.sv
// ----------------------------------------------------------------------------
// Dispatcher RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dctd_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/dependency_count_task_dispatcher.sv
// ----------------------------------------------------------------------------
// Dependency count task dispatcher
// Task table with pending counts; each step dispatches the first ready task
// and releases its successors.
// ----------------------------------------------------------------------------
// Usage: in_ch carries load and step words, out_ch carries dispatch results.
// A load word writes one table entry and produces no result.
// A step word dispatches the lowest ready entry, then follows its two
// successor links, dispatching any successor whose count drops to zero.
// Each count update is a read-modify-write of the count RAM; no two overlap.
// When nothing is ready the step gives a single none_ready result.
// The one to three results of a step are then presented one per cycle,
// last marking the final one; out_ch.ready low holds them in place and no
// new word is accepted until the last result is taken.
// Reset empties the table at once (per-entry flags); counts, links and
// operation kinds are undefined until loaded.
// ----------------------------------------------------------------------------
`include "dependency_count_task_dispatcher_assert.svh"

module dependency_count_task_dispatcher #(
  parameter int MAX_TASKS = 32
) (
  input logic clk,
  input logic rst_n,
  dctd_in_if.sink    in_ch,
  dctd_out_if.source out_ch
);

  localparam int IDX_SPAN = 1 << dctd_pkg::IDX_W;
  localparam int NT       = (MAX_TASKS < IDX_SPAN) ? MAX_TASKS : IDX_SPAN;
  localparam int AW       = (NT > 1) ? $clog2(NT) : 1;
  localparam int LNK_W    = $bits(dctd_pkg::entry_t);
  localparam int CW       = dctd_pkg::CNT_W;
  localparam int IW       = dctd_pkg::IDX_W;
  localparam int RN_W     = $clog2(dctd_pkg::RES_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_HEAD   = 9'b000000010,
    S_FISSUE = 9'b000000100,
    S_FCHK   = 9'b000001000,
    S_DA     = 9'b000010000,
    S_DAWR   = 9'b000100000,
    S_DB     = 9'b001000000,
    S_DBWR   = 9'b010000000,
    S_DRAIN  = 9'b100000000
  } state_t;

  function automatic logic link_ok(dctd_pkg::link_t l);
    return l.valid && (32'(l.idx) < MAX_TASKS);
  endfunction

  state_t            state_r, state_nxt;
  logic [NT-1:0]     loaded_r, loaded_nxt;
  logic [NT-1:0]     running_r, running_nxt;
  logic [NT-1:0]     zero_r, zero_nxt;
  logic              which_r, which_nxt;
  dctd_pkg::link_t   l1_r, l1_nxt, l2_r, l2_nxt;
  dctd_pkg::link_t   ca_r, ca_nxt, cb_r, cb_nxt;
  logic [AW-1:0]     s_r, s_nxt;
  logic [IW-1:0]     res_idx_r  [dctd_pkg::RES_DEPTH];
  logic [IW-1:0]     res_idx_nxt[dctd_pkg::RES_DEPTH];
  logic              res_op_r   [dctd_pkg::RES_DEPTH];
  logic              res_op_nxt [dctd_pkg::RES_DEPTH];
  logic              res_none_r, res_none_nxt;
  logic [RN_W-1:0]   res_n_r, res_n_nxt;
  logic [RN_W-1:0]   rd_ptr_r, rd_ptr_nxt;

  logic              in_acc, out_acc;
  logic [NT-1:0]     ready_vec;
  logic              found;
  logic [AW-1:0]     head;
  logic              ld_ok;
  logic [AW-1:0]     ld_addr;
  dctd_pkg::link_t   cur_link;

  logic              cnt_we, cnt_re;
  logic [AW-1:0]     cnt_waddr, cnt_raddr;
  logic [CW-1:0]     cnt_wdata, cnt_rdata, cnt_dec;
  logic              lk_we, lk_re;
  logic [AW-1:0]     lk_waddr, lk_raddr;
  logic [LNK_W-1:0]  lk_wdata, lk_rdata;
  dctd_pkg::entry_t  lk_rd, lk_ld;

  dctd_ram #(.WIDTH(CW), .DEPTH(NT)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  dctd_ram #(.WIDTH(LNK_W), .DEPTH(NT)) u_lnk_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  assign lk_rd    = lk_rdata;
  assign cnt_dec  = cnt_rdata - CW'(1);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign ld_ok    = 32'(in_ch.task_index) < MAX_TASKS;
  assign ld_addr  = in_ch.task_index[AW-1:0];
  assign cur_link = which_r ? l2_r : l1_r;

  assign lk_ld.op       = in_ch.op_kind;
  assign lk_ld.s1.valid = in_ch.succ1_valid;
  assign lk_ld.s1.idx   = in_ch.succ1_index;
  assign lk_ld.s2.valid = in_ch.succ2_valid;
  assign lk_ld.s2.idx   = in_ch.succ2_index;

  assign ready_vec = loaded_r & ~running_r & zero_r;
  assign found     = |ready_vec;

  always_comb begin
    head = '0;
    for (int i = NT - 1; i >= 0; i--) begin
      if (ready_vec[i]) begin
        head = AW'(i);
      end
    end
  end

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = (state_r == S_DRAIN);
  assign out_ch.dispatched_index = res_idx_r[rd_ptr_r];
  assign out_ch.dispatched_op    = res_op_r[rd_ptr_r];
  assign out_ch.none_ready       = res_none_r;
  assign out_ch.last             = (rd_ptr_r == RN_W'(res_n_r - RN_W'(1)));

  always_comb begin
    state_nxt    = state_r;
    loaded_nxt   = loaded_r;
    running_nxt  = running_r;
    zero_nxt     = zero_r;
    which_nxt    = which_r;
    l1_nxt       = l1_r;
    l2_nxt       = l2_r;
    ca_nxt       = ca_r;
    cb_nxt       = cb_r;
    s_nxt        = s_r;
    res_idx_nxt  = res_idx_r;
    res_op_nxt   = res_op_r;
    res_none_nxt = res_none_r;
    res_n_nxt    = res_n_r;
    rd_ptr_nxt   = rd_ptr_r;
    cnt_we       = 1'b0;
    cnt_waddr    = s_r;
    cnt_wdata    = cnt_dec;
    cnt_re       = 1'b0;
    cnt_raddr    = s_r;
    lk_we        = 1'b0;
    lk_waddr     = ld_addr;
    lk_wdata     = lk_ld;
    lk_re        = 1'b0;
    lk_raddr     = head;

    unique case (state_r)
      S_IDLE: begin
        rd_ptr_nxt = '0;
        if (in_acc) begin
          if (in_ch.req_type == dctd_pkg::REQ_LOAD) begin
            if (ld_ok) begin
              lk_we                = 1'b1;
              cnt_we               = 1'b1;
              cnt_waddr            = ld_addr;
              cnt_wdata            = CW'(in_ch.pred_count);
              loaded_nxt[ld_addr]  = 1'b1;
              running_nxt[ld_addr] = 1'b0;
              zero_nxt[ld_addr]    = (in_ch.pred_count == '0);
            end
          end else if (found) begin
            lk_re             = 1'b1;
            running_nxt[head] = 1'b1;
            res_idx_nxt[0]    = IW'(head);
            res_none_nxt      = 1'b0;
            res_n_nxt         = RN_W'(1);
            state_nxt         = S_HEAD;
          end else begin
            res_idx_nxt[0] = '0;
            res_op_nxt[0]  = 1'b0;
            res_none_nxt   = 1'b1;
            res_n_nxt      = RN_W'(1);
            state_nxt      = S_DRAIN;
          end
        end
      end
      S_HEAD: begin
        res_op_nxt[0] = lk_rd.op;
        l1_nxt        = lk_rd.s1;
        l2_nxt        = lk_rd.s2;
        which_nxt     = 1'b0;
        state_nxt     = S_FISSUE;
      end
      S_FISSUE: begin
        if (link_ok(cur_link)) begin
          cnt_re    = 1'b1;
          cnt_raddr = cur_link.idx[AW-1:0];
          lk_re     = 1'b1;
          lk_raddr  = cur_link.idx[AW-1:0];
          s_nxt     = cur_link.idx[AW-1:0];
          state_nxt = S_FCHK;
        end else if (!which_r) begin
          which_nxt = 1'b1;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_FCHK: begin
        cnt_we        = 1'b1;
        zero_nxt[s_r] = (cnt_dec == '0);
        if ((cnt_dec == '0) && loaded_r[s_r]) begin
          running_nxt[s_r]     = 1'b1;
          res_idx_nxt[res_n_r] = IW'(s_r);
          res_op_nxt[res_n_r]  = lk_rd.op;
          res_n_nxt            = res_n_r + RN_W'(1);
          ca_nxt               = lk_rd.s1;
          cb_nxt               = lk_rd.s2;
          state_nxt            = S_DA;
        end else if (!which_r) begin
          which_nxt = 1'b1;
          state_nxt = S_FISSUE;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DA: begin
        if (link_ok(ca_r)) begin
          cnt_re    = 1'b1;
          cnt_raddr = ca_r.idx[AW-1:0];
          state_nxt = S_DAWR;
        end else begin
          state_nxt = S_DB;
        end
      end
      S_DAWR: begin
        cnt_we                     = 1'b1;
        cnt_waddr                  = ca_r.idx[AW-1:0];
        zero_nxt[ca_r.idx[AW-1:0]] = (cnt_dec == '0);
        state_nxt                  = S_DB;
      end
      S_DB: begin
        if (link_ok(cb_r)) begin
          cnt_re    = 1'b1;
          cnt_raddr = cb_r.idx[AW-1:0];
          state_nxt = S_DBWR;
        end else if (!which_r) begin
          which_nxt = 1'b1;
          state_nxt = S_FISSUE;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DBWR: begin
        cnt_we                     = 1'b1;
        cnt_waddr                  = cb_r.idx[AW-1:0];
        zero_nxt[cb_r.idx[AW-1:0]] = (cnt_dec == '0);
        if (!which_r) begin
          which_nxt = 1'b1;
          state_nxt = S_FISSUE;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (out_acc) begin
          if (out_ch.last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_ptr_nxt = rd_ptr_r + RN_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      loaded_r  <= '0;
      running_r <= '0;
      zero_r    <= '0;
      which_r   <= 1'b0;
      res_n_r   <= '0;
      rd_ptr_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      loaded_r  <= loaded_nxt;
      running_r <= running_nxt;
      zero_r    <= zero_nxt;
      which_r   <= which_nxt;
      res_n_r   <= res_n_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l1_r       <= l1_nxt;
    l2_r       <= l2_nxt;
    ca_r       <= ca_nxt;
    cb_r       <= cb_nxt;
    s_r        <= s_nxt;
    res_idx_r  <= res_idx_nxt;
    res_op_r   <= res_op_nxt;
    res_none_r <= res_none_nxt;
  end

  // count RAM read-modify-write never overlaps a read
  `DCTD_ASSERT_NEVER(a_cnt_rw_overlap, clk, rst_n,
    cnt_we && cnt_re, "count RAM read during write")
  `DCTD_ASSERT_IMPLY(a_no_accept_with_result, clk, rst_n,
    in_acc, !out_ch.valid, "word accepted while result pending")
  `DCTD_ASSERT_NEXT(a_head_running, clk, rst_n,
    in_acc && (in_ch.req_type == dctd_pkg::REQ_STEP) && found,
    running_r[$past(head)], "head not marked running")
  `DCTD_ASSERT_NEXT(a_idle_after_last, clk, rst_n,
    out_acc && out_ch.last, in_ch.ready, "not ready after last result")
  `DCTD_ASSERT_IMPLY(a_drain_nonempty, clk, rst_n,
    state_r == S_DRAIN, res_n_r != '0, "draining with no results")

endmodule
